// ===== design/ufp_pkg.sv =====
`default_nettype none
package ufp_pkg;

   // Parser phases; code 7 is unused and behaves like waiting for the first sync.
   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_CMD   = 3'd2,
      PH_LENLO = 3'd3,
      PH_LENHI = 3'd4,
      PH_DATA  = 3'd5,
      PH_CHECK = 3'd6
   } ufp_phase_type;

   // Result kinds.
   localparam logic [1:0] KIND_EVENT = 2'd0;
   localparam logic [1:0] KIND_REPLY = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Event types.
   localparam logic [2:0] EV_BUTTON  = 3'd0;
   localparam logic [2:0] EV_BATTERY = 3'd1;
   localparam logic [2:0] EV_CHARGE  = 3'd2;
   localparam logic [2:0] EV_VERSION = 3'd3;
   localparam logic [2:0] EV_UNKNOWN = 3'd4;

   // Command codes.
   localparam logic [7:0] CMD_BUTTON  = 8'd1;
   localparam logic [7:0] CMD_BATTERY = 8'd2;
   localparam logic [7:0] CMD_CHARGE  = 8'd3;
   localparam logic [7:0] CMD_VERSION = 8'd4;

   // Acknowledge frame constants.
   localparam logic [7:0] ACK_SYNC_A  = 8'h5A;
   localparam logic [7:0] ACK_SYNC_B  = 8'hA5;
   localparam logic [7:0] ACK_ONE     = 8'h01;
   localparam logic [7:0] ACK_ZERO    = 8'h00;
   localparam logic [7:0] CODE_BTN1   = 8'hF1;
   localparam logic [7:0] CODE_BTN3   = 8'hFC;
   localparam logic [7:0] CODE_CHG4   = 8'hF4;
   localparam logic [7:0] CODE_CHGX   = 8'hF5;
   localparam int         ACK_LEN     = 7;

   // Register reset values.
   localparam logic [7:0] SYNC_FIRST_RESET  = 8'h5A;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'hA5;

   // Register indexes.
   localparam logic REG_SYNC_FIRST  = 1'b0;
   localparam logic REG_SYNC_SECOND = 1'b1;

   // Descriptor queue between parser and result generator.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;

   // One finished frame as seen by the result generator.
   typedef struct packed {
      logic        err;
      logic [2:0]  event_type;
      logic [31:0] event_value;
      logic        reply;
      logic [7:0]  code;
   } ufp_desc_type;

   // Byte idx of the acknowledge frame; the checksum of the first six
   // bytes folds to code + 1.
   function automatic logic [7:0] ack_byte(input logic [2:0] idx, input logic [7:0] code);
      logic [7:0] b;
      case (idx)
         3'd0:    b = ACK_SYNC_A;
         3'd1:    b = ACK_SYNC_B;
         3'd2:    b = ACK_ONE;
         3'd3:    b = ACK_ONE;
         3'd4:    b = ACK_ZERO;
         3'd5:    b = code;
         default: b = code + ACK_ONE;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ===== design/ufp_front.sv =====
`default_nettype none
module ufp_front #(
   parameter int VALUE_BYTES = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          rx_byte,
   input  wire logic                csr_write,
   input  wire logic                csr_index,
   input  wire logic [7:0]          csr_data,
   output logic                     desc_push,
   output ufp_pkg::ufp_desc_type    desc
);
   import ufp_pkg::*;

   // Bytes of the payload that enter the value, never more than 32 bits.
   localparam int KEEP_BYTES = (VALUE_BYTES < 4) ? VALUE_BYTES : 4;

   ufp_phase_type phase_ff, phase_in;
   logic [7:0]  sync_first_ff, sync_second_ff;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] br_ff, br_in;
   logic [31:0] val_ff, val_in;
   logic [7:0]  sum_plus;
   logic [15:0] br_next;
   logic [15:0] len_full;
   logic [4:0]  shift;

   assign sum_plus = sum_ff + rx_byte;
   assign br_next  = br_ff + 16'd1;
   assign len_full = {rx_byte, len_ff[7:0]};
   assign shift    = {br_ff[1:0], 3'b000};

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_SYNC_FIRST) sync_first_ff <= csr_data;
         if (csr_index == REG_SYNC_SECOND) sync_second_ff <= csr_data;
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC2: phase_in = (rx_byte == sync_second_ff) ? PH_CMD : PH_SYNC1;
            PH_CMD:   phase_in = PH_LENLO;
            PH_LENLO: phase_in = PH_LENHI;
            PH_LENHI: phase_in = (len_full == 16'd0) ? PH_CHECK : PH_DATA;
            PH_DATA:  phase_in = (br_next >= len_ff) ? PH_CHECK : PH_DATA;
            PH_CHECK: phase_in = PH_SYNC1;
            default:  phase_in = (rx_byte == sync_first_ff) ? PH_SYNC2 : PH_SYNC1;
         endcase
      end
   end

   // Frame fields and running checksum.
   always_comb begin
      sum_in = sum_ff;
      cmd_in = cmd_ff;
      len_in = len_ff;
      br_in  = br_ff;
      val_in = val_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC2: sum_in = (rx_byte == sync_second_ff) ? sum_plus : 8'd0;
            PH_CMD: begin
               cmd_in = rx_byte;
               sum_in = sum_plus;
            end
            PH_LENLO: begin
               len_in = {8'd0, rx_byte};
               sum_in = sum_plus;
            end
            PH_LENHI: begin
               len_in = len_full;
               val_in = 32'd0;
               br_in  = 16'd0;
               sum_in = sum_plus;
            end
            PH_DATA: begin
               sum_in = sum_plus;
               if (cmd_ff != CMD_VERSION && br_ff < 16'(KEEP_BYTES))
                  val_in = val_ff | (32'(rx_byte) << shift);
               br_in = br_next;
            end
            PH_CHECK: begin
               sum_in = 8'd0;
               len_in = 16'd0;
            end
            default: sum_in = (rx_byte == sync_first_ff) ? sum_plus : 8'd0;
         endcase
      end
   end

   // Classification of a finished frame.
   always_comb begin
      desc_push        = accept && (phase_ff == PH_CHECK);
      desc.err         = (rx_byte != sum_ff);
      desc.event_value = val_ff;
      desc.reply       = 1'b0;
      desc.code        = CODE_CHGX;
      unique case (cmd_ff)
         CMD_BUTTON: begin
            desc.event_type = EV_BUTTON;
            desc.reply      = (val_ff == 32'd1) || (val_ff == 32'd3);
            desc.code       = (val_ff == 32'd1) ? CODE_BTN1 : CODE_BTN3;
         end
         CMD_BATTERY: desc.event_type = EV_BATTERY;
         CMD_CHARGE: begin
            desc.event_type = EV_CHARGE;
            desc.reply      = 1'b1;
            desc.code       = (val_ff == 32'd4) ? CODE_CHG4 : CODE_CHGX;
         end
         CMD_VERSION: begin
            desc.event_type  = EV_VERSION;
            desc.event_value = 32'd0;
         end
         default: desc.event_type = EV_UNKNOWN;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         sum_ff   <= 8'd0;
         cmd_ff   <= 8'd0;
         len_ff   <= 16'd0;
         br_ff    <= 16'd0;
         val_ff   <= 32'd0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         br_ff    <= br_in;
         val_ff   <= val_in;
      end
   end

   // A descriptor leaves only on a checksum byte, and the parser then restarts.
   a_push_restarts: assert property (@(posedge clock) disable iff (reset)
      desc_push |=> (phase_ff == PH_SYNC1) && (sum_ff == 8'd0))
      else $error("parser did not restart after a checksum byte");

   // The count of payload bytes never passes the length while collecting.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (br_ff < len_ff))
      else $error("payload count passed the frame length");

   // Unused phase code is never entered.
   a_phase_used: assert property (@(posedge clock) disable iff (reset)
      phase_ff != ufp_phase_type'(3'd7))
      else $error("parser entered an unused phase");

endmodule
`default_nettype wire

// ===== design/ufp_fifo.sv =====
`default_nettype none
module ufp_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  ufp_pkg::ufp_desc_type    push_data,
   input  wire logic                pop,
   output logic                     full,
   output logic                     empty,
   output ufp_pkg::ufp_desc_type    head
);
   import ufp_pkg::*;

   ufp_desc_type slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff, rd_ff;
   logic [FIFO_PTR_W:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Occupancy after this beat.
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // Descriptor storage.
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

   // Occupancy stays within the depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
      else $error("descriptor queue overflow");

   // Occupancy agrees with the pointers.
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (wr_ff - rd_ff) == count_ff[FIFO_PTR_W-1:0])
      else $error("queue pointers disagree with occupancy");

   // A push into a queue that is full is never offered.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("descriptor pushed into a full queue");

endmodule
`default_nettype wire

// ===== design/ufp_back.sv =====
`default_nettype none
module ufp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                desc_empty,
   input  ufp_pkg::ufp_desc_type    desc,
   output logic                     desc_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [1:0]               rsp_result_kind,
   output logic [2:0]               rsp_event_type,
   output logic [31:0]              rsp_event_value,
   output logic [7:0]               rsp_reply_byte,
   output logic                     rsp_last_of_run
);
   import ufp_pkg::*;

   logic [2:0]  step_ff, step_in;
   logic        valid_ff;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  type_ff, type_in;
   logic [31:0] value_ff, value_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        advance;
   logic        final_step;

   // A new result enters the output register when it is free or being taken.
   assign advance    = !desc_empty && (!valid_ff || rsp_pop);
   assign final_step = (step_ff == 3'(ACK_LEN)) || (step_ff == 3'd0 && (desc.err || !desc.reply));
   assign desc_pop   = advance && final_step;

   // Result for the current step of the head descriptor.
   always_comb begin
      kind_in  = KIND_REPLY;
      type_in  = EV_BUTTON;
      value_in = 32'd0;
      byte_in  = ack_byte(step_ff - 3'd1, desc.code);
      last_in  = final_step;
      step_in  = final_step ? 3'd0 : step_ff + 3'd1;
      if (step_ff == 3'd0) begin
         byte_in = 8'd0;
         if (desc.err) begin
            kind_in = KIND_ERROR;
         end else begin
            kind_in  = KIND_EVENT;
            type_in  = desc.event_type;
            value_in = desc.event_value;
         end
      end
   end

   // Step counter and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            step_ff  <= step_in;
            valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff  <= kind_in;
         type_ff  <= type_in;
         value_ff <= value_in;
         byte_ff  <= byte_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_event_type  = type_ff;
   assign rsp_event_value = value_ff;
   assign rsp_reply_byte  = byte_ff;
   assign rsp_last_of_run = last_ff;

   // Mid-reply, the head descriptor is still queued.
   a_step_has_head: assert property (@(posedge clock) disable iff (reset)
      (step_ff != 3'd0) |-> !desc_empty)
      else $error("reply in progress without a descriptor");

   // Mid-reply, the head is a good frame that asks for an acknowledge.
   a_step_is_reply: assert property (@(posedge clock) disable iff (reset)
      (step_ff != 3'd0) |-> (desc.reply && !desc.err))
      else $error("reply step on a descriptor without a reply");

   // The step counter never passes the frame length.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 3'(ACK_LEN))
      else $error("reply step out of range");

endmodule
`default_nettype wire

// ===== design/uart_frame_parser_with_reply.sv =====
`default_nettype none
// Channel  Ports                                  Beat
// -------  -------------------------------------  --------------------------------
// input    req_push, req_full, req_rx_byte        push high and full low
// result   rsp_empty, rsp_pop, rsp_result_kind..  pop high and empty low
// config   csr_write, csr_index, csr_data         write high, no wait
//
// One received byte is taken per cycle while the descriptor queue has room.
// Each checksum byte queues one descriptor; the result generator turns it into
// one result, or eight for an acknowledged event, at one result per cycle while results are popped.
// The result register is reloaded in the cycle it is popped, so results drain
// back to back; req_full rises only when four finished frames are waiting.
// Reset is synchronous and active high; no clearing pass follows it.
module uart_frame_parser_with_reply #(
   parameter int VALUE_BYTES = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_result_kind,
   output logic [2:0]       rsp_event_type,
   output logic [31:0]      rsp_event_value,
   output logic [7:0]       rsp_reply_byte,
   output logic             rsp_last_of_run,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);
   import ufp_pkg::*;

   ufp_desc_type push_desc, head_desc;
   logic push, pop, q_full, q_empty, accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   ufp_front #(.VALUE_BYTES(VALUE_BYTES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .desc_push (push),
      .desc      (push_desc)
   );

   ufp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_desc),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head_desc)
   );

   ufp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .desc_empty      (q_empty),
      .desc            (head_desc),
      .desc_pop        (pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_event_type  (rsp_event_type),
      .rsp_event_value (rsp_event_value),
      .rsp_reply_byte  (rsp_reply_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
`default_nettype wire

// ===== test/uart_frame_parser_with_reply_tb.sv =====
`default_nettype none
module uart_frame_parser_with_reply_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ufp_pkg::*;

   localparam int VALUE_BYTES      = 4;
   localparam int RESET_CYCLES     = 11;
   localparam int SETTLE_CYCLES    = 8;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int PHASE_COUNT      = 6;
   localparam int RANDOM_PER_PHASE = 32;
   localparam int DIRECTED_COUNT   = 23;

   // One result beat as the block presents it.
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  ev_type;
      logic [31:0] value;
      logic [7:0]  reply;
      logic        last;
   } frame_result_type;

   // How a directed row is checked.
   typedef enum logic [1:0] {
      ROW_MODEL,
      ROW_QUIET,
      ROW_SINGLE
   } row_check_type;

   typedef struct packed {
      logic [7:0]    rx;
      row_check_type mode;
      logic [1:0]    kind;
      logic [2:0]    ev_type;
      logic [31:0]   value;
      logic [7:0]    reply;
   } stim_row_type;

   // Directed bytes under the reset sync values; typed rows carry their single result.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Zero-length battery frame right out of reset.
      '{8'h5A, ROW_QUIET,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'hA5, ROW_QUIET,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h02, ROW_QUIET,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h00, ROW_QUIET,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h00, ROW_QUIET,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h01, ROW_SINGLE, KIND_EVENT, EV_BATTERY, 32'd0, 8'h00},
      // A wrong second sync that equals the first sync, then a wrong first sync.
      '{8'h5A, ROW_QUIET,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h5A, ROW_QUIET,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'hA5, ROW_QUIET,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      // Button value 1 with its acknowledge frame.
      '{8'h5A, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'hA5, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h01, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h01, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h00, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h01, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h02, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      // Charge frame with an all-ones payload byte and a bad checksum.
      '{8'h5A, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'hA5, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h03, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h01, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h00, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'hFF, ROW_MODEL,  KIND_EVENT, EV_BUTTON,  32'd0, 8'h00},
      '{8'h00, ROW_SINGLE, KIND_ERROR, EV_BUTTON,  32'd0, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [2:0]  rsp_event_type;
   logic [31:0] rsp_event_value;
   logic [7:0]  rsp_reply_byte;
   logic        rsp_last_of_run;
   logic        csr_write = 1'b0;
   logic        csr_index = REG_SYNC_FIRST;
   logic [7:0]  csr_data = 8'h00;

   // Mirror of the parser state and the sync registers.
   ufp_phase_type frame_phase = PH_SYNC1;
   logic [7:0]  frame_sum = 8'h00;
   logic [7:0]  frame_cmd = 8'h00;
   logic [15:0] frame_len = 16'h0000;
   logic [15:0] frame_count = 16'h0000;
   logic [31:0] frame_value = 32'h0;
   logic [7:0]  want_sync_first = SYNC_FIRST_RESET;
   logic [7:0]  want_sync_second = SYNC_SECOND_RESET;

   frame_result_type pending_results[$];
   int  error_count = 0;
   int  bytes_sent = 0;
   int  cycle_count = 0;
   int  rsp_hold = 0;
   bit  req_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;

   uart_frame_parser_with_reply #(
      .VALUE_BYTES(VALUE_BYTES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_rx_byte(req_rx_byte),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_result_kind(rsp_result_kind),
      .rsp_event_type(rsp_event_type),
      .rsp_event_value(rsp_event_value),
      .rsp_reply_byte(rsp_reply_byte),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic frame_result_type make_result(input logic [1:0] kind,
                                                    input logic [2:0] ev_type,
                                                    input logic [31:0] value,
                                                    input logic [7:0] reply);
      frame_result_type r;
      r.kind    = kind;
      r.ev_type = ev_type;
      r.value   = value;
      r.reply   = reply;
      r.last    = 1'b0;
      return r;
   endfunction

   // Mostly back to back, sometimes a short gap, rarely a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Advance the parser mirror by one byte and queue the results it causes.
   task automatic parse_rx_byte(input logic [7:0] b, input bit keep);
      frame_result_type batch[$];
      logic [7:0] ack [ACK_LEN];
      logic [7:0] code;
      bit send_ack;
      send_ack = 1'b0;
      code = ACK_ZERO;
      case (frame_phase)
         PH_SYNC2: begin
            if (b == want_sync_second) begin
               frame_sum = frame_sum + b;
               frame_phase = PH_CMD;
            end else begin
               frame_sum = 8'h00;
               frame_phase = PH_SYNC1;
            end
         end
         PH_CMD: begin
            frame_cmd = b;
            frame_sum = frame_sum + b;
            frame_phase = PH_LENLO;
         end
         PH_LENLO: begin
            frame_len = {8'h00, b};
            frame_sum = frame_sum + b;
            frame_phase = PH_LENHI;
         end
         PH_LENHI: begin
            frame_len[15:8] = b;
            frame_value = 32'h0;
            frame_count = 16'h0000;
            frame_sum = frame_sum + b;
            frame_phase = (frame_len == 16'h0000) ? PH_CHECK : PH_DATA;
         end
         PH_DATA: begin
            // Only the leading payload bytes build the value; all of them feed the sum.
            frame_sum = frame_sum + b;
            if (frame_cmd != CMD_VERSION && frame_count < VALUE_BYTES && frame_count < 4)
               frame_value = frame_value | (32'(b) << (8 * frame_count));
            frame_count = frame_count + 16'd1;
            if (frame_count >= frame_len)
               frame_phase = PH_CHECK;
         end
         PH_CHECK: begin
            if (b == frame_sum) begin
               case (frame_cmd)
                  CMD_BUTTON: begin
                     batch.push_back(make_result(KIND_EVENT, EV_BUTTON, frame_value, 8'h00));
                     if (frame_value == 32'd1) begin
                        send_ack = 1'b1;
                        code = CODE_BTN1;
                     end else if (frame_value == 32'd3) begin
                        send_ack = 1'b1;
                        code = CODE_BTN3;
                     end
                  end
                  CMD_BATTERY:
                     batch.push_back(make_result(KIND_EVENT, EV_BATTERY, frame_value, 8'h00));
                  CMD_CHARGE: begin
                     batch.push_back(make_result(KIND_EVENT, EV_CHARGE, frame_value, 8'h00));
                     send_ack = 1'b1;
                     code = (frame_value == 32'd4) ? CODE_CHG4 : CODE_CHGX;
                  end
                  CMD_VERSION:
                     batch.push_back(make_result(KIND_EVENT, EV_VERSION, 32'd0, 8'h00));
                  default:
                     batch.push_back(make_result(KIND_EVENT, EV_UNKNOWN, frame_value, 8'h00));
               endcase
            end else begin
               batch.push_back(make_result(KIND_ERROR, EV_BUTTON, 32'd0, 8'h00));
            end
            frame_phase = PH_SYNC1;
            frame_sum = 8'h00;
            frame_len = 16'h0000;
         end
         default: begin
            // Waiting for the first sync byte; the unused phase code lands here too.
            if (b == want_sync_first) begin
               frame_sum = frame_sum + b;
               frame_phase = PH_SYNC2;
            end else begin
               frame_sum = 8'h00;
               frame_phase = PH_SYNC1;
            end
         end
      endcase

      // The acknowledge frame always uses the fixed sync bytes and ends with its sum.
      if (send_ack) begin
         ack[0] = ACK_SYNC_A;
         ack[1] = ACK_SYNC_B;
         ack[2] = ACK_ONE;
         ack[3] = ACK_ONE;
         ack[4] = ACK_ZERO;
         ack[5] = code;
         ack[6] = 8'h00;
         for (int k = 0; k < 6; k++)
            ack[6] = ack[6] + ack[k];
         for (int k = 0; k < ACK_LEN; k++)
            batch.push_back(make_result(KIND_REPLY, EV_BUTTON, 32'd0, ack[k]));
      end

      if (batch.size() > 0)
         batch[batch.size() - 1].last = 1'b1;
      if (keep) begin
         foreach (batch[i])
            pending_results.push_back(batch[i]);
      end
   endtask

   // Offer one byte and wait for its beat; push stays high when the next byte follows at once.
   task automatic send_byte(input logic [7:0] b, input bit keep);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      parse_rx_byte(b, keep);
      bytes_sent++;
   endtask

   // Stop offering bytes, let every expected beat come out, then let the parser settle.
   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_syncs(input logic [7:0] first, input logic [7:0] second);
      drain_results();
      csr_write <= 1'b1;
      csr_index <= REG_SYNC_FIRST;
      csr_data <= first;
      @(posedge clock);
      csr_index <= REG_SYNC_SECOND;
      csr_data <= second;
      @(posedge clock);
      csr_write <= 1'b0;
      want_sync_first = first;
      want_sync_second = second;
   endtask

   // One random frame: mostly well formed, some noise, bad syncs, bad sums and truncations.
   task automatic send_random_frame(input bit big);
      logic [7:0] body[$];
      logic [7:0] cmd;
      logic [7:0] lead;
      logic [7:0] b;
      logic [7:0] sum;
      logic [15:0] len;
      int pick;
      int r;
      bit special;
      pick = big ? 99 : $urandom_range(0, 99);
      if (pick < 6) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 12) begin
         send_byte(want_sync_first, 1'b1);
         send_byte(want_sync_second ^ 8'($urandom_range(1, 255)), 1'b1);
      end else begin
         r = $urandom_range(0, 9);
         if (r < 3)
            cmd = CMD_BUTTON;
         else if (r < 4)
            cmd = CMD_BATTERY;
         else if (r < 6)
            cmd = CMD_CHARGE;
         else if (r < 7)
            cmd = CMD_VERSION;
         else
            cmd = 8'($urandom_range(0, 255));

         r = $urandom_range(0, 99);
         if (big)
            len = 16'h0100 + 16'($urandom_range(0, 4));
         else if (pick < 18)
            len = 16'($urandom_range(1, 3));
         else if (r < 15)
            len = 16'd0;
         else if (r < 75)
            len = 16'($urandom_range(1, 4));
         else if (r < 95)
            len = 16'($urandom_range(5, 12));
         else
            len = 16'($urandom_range(13, 30));

         body = {want_sync_first, want_sync_second, cmd, len[7:0], len[15:8]};

         // Half the payloads lead with 1, 3 or 4 so that acknowledges and both charge codes occur.
         special = $urandom_range(0, 1);
         r = $urandom_range(0, 2);
         lead = (r == 0) ? 8'd1 : ((r == 1) ? 8'd3 : 8'd4);
         if (pick >= 18) begin
            for (int i = 0; i < len; i++) begin
               b = 8'($urandom_range(0, 255));
               if (special && i == 0)
                  b = lead;
               else if (special && i < 4)
                  b = 8'h00;
               body.push_back(b);
            end
            sum = 8'h00;
            foreach (body[i])
               sum = sum + body[i];
            if (pick < 28)
               sum = sum ^ 8'($urandom_range(1, 255));
            body.push_back(sum);
         end

         foreach (body[i])
            send_byte(body[i], 1'b1);
      end
   endtask

   // Result side: check each beat against the oldest expectation, then choose the next pop.
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               $error("result beat with nothing expected: kind %0d", rsp_result_kind);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_result_kind !== want.kind) begin
                  $error("result_kind: expected %0d, actual %0d", want.kind, rsp_result_kind);
                  error_count++;
               end
               if (rsp_event_type !== want.ev_type) begin
                  $error("event_type: expected %0d, actual %0d", want.ev_type, rsp_event_type);
                  error_count++;
               end
               if (rsp_event_value !== want.value) begin
                  $error("event_value: expected %08h, actual %08h", want.value,
                         rsp_event_value);
                  error_count++;
               end
               if (rsp_reply_byte !== want.reply) begin
                  $error("reply_byte: expected %02h, actual %02h", want.reply, rsp_reply_byte);
                  error_count++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $error("last_of_run: expected %0d, actual %0d", want.last, rsp_last_of_run);
                  error_count++;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (rsp_idle_on)
               rsp_hold = pick_gap();
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Reset, directed table, then random phases under several sync settings.
   initial begin
      int phase_end;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].mode == ROW_MODEL);
         if (DIRECTED_ROWS[i].mode == ROW_SINGLE) begin
            pending_results.push_back('{kind: DIRECTED_ROWS[i].kind,
                                        ev_type: DIRECTED_ROWS[i].ev_type,
                                        value: DIRECTED_ROWS[i].value,
                                        reply: DIRECTED_ROWS[i].reply,
                                        last: 1'b1});
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: set_syncs(8'h00, 8'hFF);
            1: set_syncs(8'hFF, 8'h00);
            2: set_syncs(SYNC_FIRST_RESET, SYNC_SECOND_RESET);
            3: set_syncs(8'h3C, 8'h3C);
            default: set_syncs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         // One phase runs the input without gaps, another the result side without stalls.
         req_idle_on = (p != 2);
         rsp_idle_on = (p != 3);
         phase_end = bytes_sent + RANDOM_PER_PHASE;
         if (p == 4)
            send_random_frame(1'b1);
         while (bytes_sent < phase_end)
            send_random_frame(1'b0);
      end

      drain_results();
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
design/ufp_pkg.sv
design/ufp_front.sv
design/ufp_fifo.sv
design/ufp_back.sv
design/uart_frame_parser_with_reply.sv
test/uart_frame_parser_with_reply_tb.sv
